@@ rtl/core/stt_pkg.sv @@
`default_nettype none

package stt_pkg;

    // token buffer size and the widths that follow from it
    localparam int TOK_MAX = 32;
    localparam int TOK_AW  = $clog2(TOK_MAX);
    localparam int TOK_LW  = $clog2(TOK_MAX + 1);

    // result kind codes
    localparam logic [3:0] KIND_SEMI    = 4'd0;
    localparam logic [3:0] KIND_LBRACE  = 4'd1;
    localparam logic [3:0] KIND_RBRACE  = 4'd2;
    localparam logic [3:0] KIND_INT     = 4'd3;
    localparam logic [3:0] KIND_FLOAT   = 4'd4;
    localparam logic [3:0] KIND_STRING  = 4'd5;
    localparam logic [3:0] KIND_ASSIGN  = 4'd6;
    localparam logic [3:0] KIND_PLUS    = 4'd7;
    localparam logic [3:0] KIND_MINUS   = 4'd8;
    localparam logic [3:0] KIND_VALUE   = 4'd9;
    localparam logic [3:0] KIND_LITERAL = 4'd10;

    // input op codes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    // characters with a meaning of their own
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ASSIGN = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // keywords that give a token its class
    localparam logic [7:0] KW_INT    [3] = '{8'h69, 8'h6E, 8'h74};
    localparam logic [7:0] KW_FLOAT  [5] = '{8'h66, 8'h6C, 8'h6F, 8'h61, 8'h74};
    localparam logic [7:0] KW_STRING [6] = '{8'h73, 8'h74, 8'h72, 8'h69, 8'h6E, 8'h67};

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_LITERAL,
        MODE_BLOCK,
        MODE_SKIP
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPEN,
        ST_FETCH,
        ST_EMIT,
        ST_CLOSE,
        ST_DELIM
    } t_state;

    // buffer update, seen by the keyword tracker
    typedef struct packed {
        logic              clr;
        logic              push;
        logic [TOK_LW-1:0] pos;
        logic [7:0]        chr;
    } t_tok_wr;

endpackage

`default_nettype wire

@@ rtl/core/stt_token_ram.sv @@
`default_nettype none

module stt_token_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/stt_kw_match.sv @@
`default_nettype none

module stt_kw_match
    import stt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_tok_wr           i_wr,
    input  wire logic [TOK_LW-1:0] i_len,
    input  wire logic              i_ovf,
    output logic      [3:0]        o_kind
);

    // prefix of the buffer still matches each keyword
    logic r_m_int, r_m_flt, r_m_str;
    logic n_m_int, n_m_flt, n_m_str;
    logic hit_int, hit_flt, hit_str;

    always_comb begin
        hit_int = 1'b0;
        hit_flt = 1'b0;
        hit_str = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (i_wr.pos == TOK_LW'(i) && i_wr.chr == KW_INT[i]) hit_int = 1'b1;
        end
        for (int i = 0; i < 5; i++) begin
            if (i_wr.pos == TOK_LW'(i) && i_wr.chr == KW_FLOAT[i]) hit_flt = 1'b1;
        end
        for (int i = 0; i < 6; i++) begin
            if (i_wr.pos == TOK_LW'(i) && i_wr.chr == KW_STRING[i]) hit_str = 1'b1;
        end
    end

    always_comb begin
        n_m_int = r_m_int;
        n_m_flt = r_m_flt;
        n_m_str = r_m_str;
        if (i_wr.clr) begin
            n_m_int = 1'b1;
            n_m_flt = 1'b1;
            n_m_str = 1'b1;
        end else if (i_wr.push) begin
            n_m_int = r_m_int & hit_int;
            n_m_flt = r_m_flt & hit_flt;
            n_m_str = r_m_str & hit_str;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_int <= 1'b1;
            r_m_flt <= 1'b1;
            r_m_str <= 1'b1;
        end else begin
            r_m_int <= n_m_int;
            r_m_flt <= n_m_flt;
            r_m_str <= n_m_str;
        end
    end

    always_comb begin
        if (i_ovf) begin
            o_kind = KIND_VALUE;
        end else if (r_m_int && i_len == TOK_LW'(3)) begin
            o_kind = KIND_INT;
        end else if (r_m_flt && i_len == TOK_LW'(5)) begin
            o_kind = KIND_FLOAT;
        end else if (r_m_str && i_len == TOK_LW'(6)) begin
            o_kind = KIND_STRING;
        end else begin
            o_kind = KIND_VALUE;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/source_text_tokenizer.sv @@
`default_nettype none

// Source text tokenizer. Each input item is one source character (op = 0) or an
// end-of-line mark (op = 1); the block splits the text into tokens and returns
// each token one character per result item, tagged with its class, the line
// number, the brace depth and a scope number. Pending token characters sit in a
// token buffer RAM with separate read and write ports and registered read data,
// and the token class is tracked as characters are written, so no second pass is
// needed. Items are taken only while no token is being sent out. A buffered
// token character takes a RAM read (FETCH), then an output register load (EMIT);
// each quote of a string literal and a one-character delimiter token has a state
// of its own (OPEN, CLOSE, DELIM); output stalls hold every load. Characters
// beyond the buffer size are dropped and the token is marked truncated. The
// buffer needs no clearing after reset: only entries already written for the
// pending token are ever read. Line numbers saturate at 65535; depth and scope wrap.

module source_text_tokenizer
    import stt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input items
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_op,
    input  wire logic        [7:0]  i_in_char,
    // result items
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic             [7:0]  o_out_char,
    output logic             [3:0]  o_kind,
    output logic             [15:0] o_line_no,
    output logic signed      [15:0] o_depth,
    output logic             [15:0] o_scope,
    output logic                    o_last_char,
    output logic                    o_truncated
);

    // sequencer
    t_state r_state, n_state;

    // tokenizer state
    t_mode              r_mode, n_mode;
    logic [7:0]         r_prev_char, n_prev_char;
    logic               r_prev_valid, n_prev_valid;
    logic [TOK_LW-1:0]  r_len, n_len;
    logic               r_ovf, n_ovf;
    logic [15:0]        r_line, n_line;
    logic signed [15:0] r_depth, n_depth;
    logic [15:0]        r_scope, n_scope;

    // token being sent out, captured when the item is taken
    logic [TOK_LW-1:0]  r_tok_len;
    logic [3:0]         r_tok_kind;
    logic               r_tok_trunc;
    logic               r_lit;
    logic               r_delim;
    logic [7:0]         r_delim_char;
    logic [3:0]         r_delim_kind;
    logic [15:0]        r_em_line;
    logic signed [15:0] r_em_depth;
    logic [15:0]        r_em_scope;
    logic [TOK_LW-1:0]  r_idx;

    // output register
    logic               r_out_valid;
    logic [7:0]         r_out_char;
    logic [3:0]         r_out_kind;
    logic               r_out_last;
    logic               r_out_trunc;
    logic [15:0]        r_out_line;
    logic signed [15:0] r_out_depth;
    logic [15:0]        r_out_scope;

    // per-item decision
    logic               acc;
    logic               after_slash, after_star;
    logic               is_space, is_delim;
    logic               go_flush, go_lit, go_delim;
    logic               tok_clr, do_append, push;
    logic [3:0]         delim_kind;
    logic [3:0]         kw_kind;
    t_tok_wr            tok_wr;

    // output load
    logic               out_free;
    logic               load;
    logic [7:0]         ld_char;
    logic [3:0]         ld_kind;
    logic               ld_last;
    logic               ld_trunc;
    logic               rd_en;
    logic               idx_last;
    logic [7:0]         rd_data;

    assign o_in_ready = (r_state == ST_IDLE);
    assign acc        = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign idx_last   = (r_idx == r_tok_len - TOK_LW'(1));

    // pairs only count when both characters are on one line
    assign after_slash = r_prev_valid && (r_prev_char == CH_SLASH);
    assign after_star  = r_prev_valid && (r_prev_char == CH_STAR);
    assign is_space    = i_in_char inside {CH_SPACE, CH_TAB};
    assign is_delim    = i_in_char inside {CH_LBRACE, CH_RBRACE, CH_ASSIGN,
                                           CH_SEMI, CH_PLUS, CH_MINUS};

    always_comb begin
        case (i_in_char)
            CH_SEMI:   delim_kind = KIND_SEMI;
            CH_LBRACE: delim_kind = KIND_LBRACE;
            CH_RBRACE: delim_kind = KIND_RBRACE;
            CH_ASSIGN: delim_kind = KIND_ASSIGN;
            CH_PLUS:   delim_kind = KIND_PLUS;
            default:   delim_kind = KIND_MINUS;
        endcase
    end

    // what one accepted item does to the tokenizer state
    always_comb begin
        n_mode       = r_mode;
        n_prev_char  = r_prev_char;
        n_prev_valid = r_prev_valid;
        n_len        = r_len;
        n_ovf        = r_ovf;
        n_line       = r_line;
        n_depth      = r_depth;
        n_scope      = r_scope;
        go_flush     = 1'b0;
        go_lit       = 1'b0;
        go_delim     = 1'b0;
        tok_clr      = 1'b0;
        do_append    = 1'b0;
        if (acc) begin
            if (i_op == OP_EOL) begin
                // a line break ends a plain token, and ends a line comment
                if (r_mode == MODE_NORMAL) begin
                    go_flush = 1'b1;
                end else if (r_mode == MODE_SKIP) begin
                    n_mode = MODE_NORMAL;
                end
                if (r_line != 16'hFFFF) begin
                    n_line = r_line + 16'd1;
                end
                n_prev_valid = 1'b0;
                n_prev_char  = 8'd0;
            end else begin
                n_prev_char  = i_in_char;
                n_prev_valid = 1'b1;
                case (r_mode)
                    MODE_LITERAL: begin
                        if (i_in_char == CH_QUOTE) begin
                            go_lit  = 1'b1;
                            tok_clr = 1'b1;
                            n_mode  = MODE_NORMAL;
                        end else begin
                            do_append = 1'b1;
                        end
                    end
                    MODE_BLOCK: begin
                        if (i_in_char == CH_SLASH && after_star) begin
                            tok_clr = 1'b1;
                            n_mode  = MODE_NORMAL;
                        end
                    end
                    MODE_SKIP: begin
                    end
                    default: begin
                        if (is_space) begin
                            go_flush = 1'b1;
                        end else if (i_in_char == CH_QUOTE) begin
                            // pending text becomes the start of the literal
                            n_mode = MODE_LITERAL;
                        end else if (i_in_char == CH_SLASH && after_slash) begin
                            tok_clr = 1'b1;
                            n_mode  = MODE_SKIP;
                        end else if (i_in_char == CH_STAR && after_slash) begin
                            // the opening slash goes with the dropped token
                            tok_clr = 1'b1;
                            n_mode  = MODE_BLOCK;
                        end else if (is_delim) begin
                            // braces move depth and scope before the flush
                            if (i_in_char == CH_LBRACE) begin
                                n_depth = r_depth + 16'sd1;
                                n_scope = r_scope + 16'd1;
                            end else if (i_in_char == CH_RBRACE) begin
                                n_depth = r_depth - 16'sd1;
                                n_scope = r_scope + 16'd1;
                            end
                            go_flush = 1'b1;
                            go_delim = 1'b1;
                        end else begin
                            do_append = 1'b1;
                        end
                    end
                endcase
            end
        end
        if (go_flush) begin
            tok_clr = 1'b1;
        end
        push = do_append && (r_len < TOK_LW'(TOK_MAX));
        if (do_append) begin
            if (push) begin
                n_len = r_len + TOK_LW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (tok_clr) begin
            n_len = '0;
            n_ovf = 1'b0;
        end
    end

    assign tok_wr.clr  = tok_clr;
    assign tok_wr.push = push;
    assign tok_wr.pos  = r_len;
    assign tok_wr.chr  = i_in_char;

    stt_kw_match u_kw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (tok_wr),
        .i_len   (r_len),
        .i_ovf   (r_ovf),
        .o_kind  (kw_kind)
    );

    // buffer writes happen only while idle and reads only while sending,
    // so the two never touch the same entry in one cycle
    stt_token_ram #(
        .DEPTH (TOK_MAX),
        .WIDTH (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_len[TOK_AW-1:0]),
        .i_wdata (i_in_char),
        .i_re    (rd_en),
        .i_raddr (r_idx[TOK_AW-1:0]),
        .o_rdata (rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (go_lit) begin
                    n_state = ST_OPEN;
                end else if (go_flush && r_len != '0) begin
                    n_state = ST_FETCH;
                end else if (go_delim) begin
                    n_state = ST_DELIM;
                end
            end
            ST_OPEN: begin
                if (out_free) begin
                    n_state = (r_tok_len != '0) ? ST_FETCH : ST_CLOSE;
                end
            end
            ST_FETCH: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (!idx_last) begin
                        n_state = ST_FETCH;
                    end else if (r_lit) begin
                        n_state = ST_CLOSE;
                    end else if (r_delim) begin
                        n_state = ST_DELIM;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_CLOSE, ST_DELIM: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer: buffer read and output register load
    always_comb begin
        rd_en    = 1'b0;
        load     = 1'b0;
        ld_char  = rd_data;
        ld_kind  = r_tok_kind;
        ld_last  = 1'b0;
        ld_trunc = r_tok_trunc;
        case (r_state)
            ST_OPEN: begin
                load    = out_free;
                ld_char = CH_QUOTE;
            end
            ST_FETCH: begin
                rd_en = 1'b1;
            end
            ST_EMIT: begin
                load    = out_free;
                ld_last = idx_last && !r_lit;
            end
            ST_CLOSE: begin
                load    = out_free;
                ld_char = CH_QUOTE;
                ld_last = 1'b1;
            end
            ST_DELIM: begin
                load     = out_free;
                ld_char  = r_delim_char;
                ld_kind  = r_delim_kind;
                ld_last  = 1'b1;
                ld_trunc = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mode       <= MODE_NORMAL;
            r_prev_char  <= 8'd0;
            r_prev_valid <= 1'b0;
            r_len        <= '0;
            r_ovf        <= 1'b0;
            r_line       <= 16'd1;
            r_depth      <= 16'sd0;
            r_scope      <= 16'd0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_prev_char  <= n_prev_char;
            r_prev_valid <= n_prev_valid;
            r_len        <= n_len;
            r_ovf        <= n_ovf;
            r_line       <= n_line;
            r_depth      <= n_depth;
            r_scope      <= n_scope;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (acc) begin
                r_idx <= '0;
            end else if (r_state == ST_EMIT && out_free) begin
                r_idx <= r_idx + TOK_LW'(1);
            end
        end
    end

    // token attributes, taken with the item that ends the token
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_tok_len    <= r_len;
            r_tok_trunc  <= r_ovf;
            r_tok_kind   <= go_lit ? KIND_LITERAL : kw_kind;
            r_lit        <= go_lit;
            r_delim      <= go_delim;
            r_delim_char <= i_in_char;
            r_delim_kind <= delim_kind;
            r_em_line    <= r_line;
            r_em_depth   <= n_depth;
            r_em_scope   <= n_scope;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_char  <= ld_char;
            r_out_kind  <= ld_kind;
            r_out_last  <= ld_last;
            r_out_trunc <= ld_trunc;
            r_out_line  <= r_em_line;
            r_out_depth <= r_em_depth;
            r_out_scope <= r_em_scope;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_kind      = r_out_kind;
    assign o_line_no   = r_out_line;
    assign o_depth     = r_out_depth;
    assign o_scope     = r_out_scope;
    assign o_last_char = r_out_last;
    assign o_truncated = r_out_trunc;

`ifndef NO_ASSERTIONS
    // pending token never outgrows the buffer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= TOK_LW'(TOK_MAX))
        else $error("token length beyond buffer size");

    // a dropped character only happens with a full buffer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_len == TOK_LW'(TOK_MAX)))
        else $error("overflow flag without full buffer");

    // buffer reads stay within the token being sent
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |-> (r_idx < r_tok_len))
        else $error("buffer read past end of token");

    // line numbers start at one and never wrap to zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != 16'd0)
        else $error("line count reached zero");

    // a delimiter item closes its own token and is never truncated
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DELIM && load) |=> (r_out_last && !r_out_trunc))
        else $error("bad delimiter item");
`endif

endmodule

`default_nettype wire

@@ sim/tb_source_text_tokenizer.sv @@
`timescale 1ns / 100ps

module tb_source_text_tokenizer;
    import stt_pkg::*;

    // run limits
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no handshake on either side
    localparam int LONG_HOLD      = 400;    // one long receiver hold-off
    localparam int DRAIN_CYCLES   = 64;
    localparam int RANDOM_ITEMS   = 85;

    // one emitted token character
    typedef struct {
        logic        [7:0]  out_char;
        logic        [3:0]  kind;
        logic        [15:0] line_no;
        logic signed [15:0] depth;
        logic        [15:0] scope;
        logic               last_char;
        logic               truncated;
    } t_tok_res;

    // one row of the directed text
    typedef struct {
        logic       op;
        logic [7:0] ch;
        bit         typed;
        t_tok_res   want;
    } t_text_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_op = OP_CHAR;
    logic [7:0] i_in_char = 8'h00;
    logic i_out_ready = 1'b0;

    logic               o_in_ready;
    logic               o_out_valid;
    logic        [7:0]  o_out_char;
    logic        [3:0]  o_kind;
    logic        [15:0] o_line_no;
    logic signed [15:0] o_depth;
    logic        [15:0] o_scope;
    logic               o_last_char;
    logic               o_truncated;

    // expected token characters, oldest first
    t_tok_res tok_expect[$];
    t_text_row text_plan[$];

    // shadow of the tokenizer state
    t_mode       lex_mode = MODE_NORMAL;
    logic [7:0]  lex_prev = 8'h00;
    bit          lex_prev_ok = 1'b0;
    logic [7:0]  tok_buf [TOK_MAX];
    int          tok_len = 0;
    bit          tok_cut = 1'b0;
    logic [15:0] line_cnt = 16'd1;
    logic [15:0] nest_lvl = 16'd0;
    logic [15:0] scope_cnt = 16'd0;

    // run bookkeeping
    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int quiet_cycles = 0;
    bit full_rate = 1'b0;     // both sides drop their idle gaps while set
    bit hold_armed = 1'b0;    // asks the receiver for its long hold-off

    source_text_tokenizer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_in_char   (i_in_char),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_char  (o_out_char),
        .o_kind      (o_kind),
        .o_line_no   (o_line_no),
        .o_depth     (o_depth),
        .o_scope     (o_scope),
        .o_last_char (o_last_char),
        .o_truncated (o_truncated)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // token predictor
    // ---------------------------------------------------------------

    task automatic emit_char(input logic [7:0] ch, input logic [3:0] k, input bit fin,
                             input bit cut);
        t_tok_res r;
        r.out_char  = ch;
        r.kind      = k;
        r.line_no   = line_cnt;
        r.depth     = nest_lvl;
        r.scope     = scope_cnt;
        r.last_char = fin;
        r.truncated = cut;
        tok_expect.insert(tok_expect.size(), r);
    endtask

    task automatic buffer_char(input logic [7:0] ch);
        if (tok_len < TOK_MAX) begin
            tok_buf[tok_len] = ch;
            tok_len++;
        end else begin
            tok_cut = 1'b1;
        end
    endtask

    function automatic bit buf_matches(string kw);
        int i;
        if (tok_len != kw.len())
            return 1'b0;
        for (i = 0; i < tok_len; i++)
            if (tok_buf[i] != kw[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // class of a finished plain token; a cut token is always a value
    function automatic logic [3:0] word_kind();
        if (tok_cut)
            return KIND_VALUE;
        if (buf_matches("int"))
            return KIND_INT;
        if (buf_matches("float"))
            return KIND_FLOAT;
        if (buf_matches("string"))
            return KIND_STRING;
        return KIND_VALUE;
    endfunction

    task automatic flush_word();
        int i;
        logic [3:0] k;
        if (tok_len == 0)
            return;
        k = word_kind();
        for (i = 0; i < tok_len; i++)
            emit_char(tok_buf[i], k, i == tok_len - 1, tok_cut);
        tok_len = 0;
        tok_cut = 1'b0;
    endtask

    // literal goes out with both quotes, all flagged if the content was cut
    task automatic flush_literal();
        int i;
        emit_char(CH_QUOTE, KIND_LITERAL, 1'b0, tok_cut);
        for (i = 0; i < tok_len; i++)
            emit_char(tok_buf[i], KIND_LITERAL, 1'b0, tok_cut);
        emit_char(CH_QUOTE, KIND_LITERAL, 1'b1, tok_cut);
        tok_len = 0;
        tok_cut = 1'b0;
    endtask

    task automatic predict_tokens(input logic op, input logic [7:0] ch);
        bit after_slash;
        bit after_star;
        logic [3:0] k;
        if (op == OP_EOL) begin
            // end of line ends a plain token, closes a line comment, not a literal
            if (lex_mode == MODE_NORMAL)
                flush_word();
            else if (lex_mode == MODE_SKIP)
                lex_mode = MODE_NORMAL;
            if (line_cnt != 16'hFFFF)
                line_cnt++;
            lex_prev_ok = 1'b0;
            lex_prev = 8'h00;
            return;
        end
        // two-character marks only pair up within one line
        after_slash = lex_prev_ok && lex_prev == CH_SLASH;
        after_star  = lex_prev_ok && lex_prev == CH_STAR;
        lex_prev = ch;
        lex_prev_ok = 1'b1;
        case (lex_mode)
            MODE_LITERAL: begin
                if (ch == CH_QUOTE) begin
                    flush_literal();
                    lex_mode = MODE_NORMAL;
                end else begin
                    buffer_char(ch);
                end
            end
            MODE_BLOCK: begin
                if (ch == CH_SLASH && after_star) begin
                    tok_len = 0;
                    tok_cut = 1'b0;
                    lex_mode = MODE_NORMAL;
                end
            end
            MODE_SKIP: ;
            default: begin
                if (ch == CH_SPACE || ch == CH_TAB) begin
                    flush_word();
                end else if (ch == CH_QUOTE) begin
                    // pending text becomes the start of the literal
                    lex_mode = MODE_LITERAL;
                end else if (ch == CH_SLASH && after_slash) begin
                    tok_len = 0;
                    tok_cut = 1'b0;
                    lex_mode = MODE_SKIP;
                end else if (ch == CH_STAR && after_slash) begin
                    // opening slash sits in the pending token and goes with it
                    tok_len = 0;
                    tok_cut = 1'b0;
                    lex_mode = MODE_BLOCK;
                end else if (ch == CH_SEMI || ch == CH_LBRACE || ch == CH_RBRACE ||
                             ch == CH_ASSIGN || ch == CH_PLUS || ch == CH_MINUS) begin
                    // braces move depth and scope before the pending token goes out
                    if (ch == CH_LBRACE) begin
                        nest_lvl++;
                        scope_cnt++;
                    end else if (ch == CH_RBRACE) begin
                        nest_lvl--;
                        scope_cnt++;
                    end
                    flush_word();
                    case (ch)
                        CH_SEMI:   k = KIND_SEMI;
                        CH_LBRACE: k = KIND_LBRACE;
                        CH_RBRACE: k = KIND_RBRACE;
                        CH_ASSIGN: k = KIND_ASSIGN;
                        CH_PLUS:   k = KIND_PLUS;
                        default:   k = KIND_MINUS;
                    endcase
                    emit_char(ch, k, 1'b1, 1'b0);
                end else begin
                    buffer_char(ch);
                end
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    // valid is only lowered when a gap follows, so it never drops and rises in one step
    task automatic send_item(input logic op, input logic [7:0] ch);
        int gap;
        gap = full_rate ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_in_char <= ch;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predict_tokens(op, ch);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(OP_CHAR, s[i]);
    endtask

    function automatic logic [7:0] pick_plain();
        string pool;
        pool = "abcdefghijklmnopqrstuvwxyz0123456789._";
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_delim();
        case ($urandom_range(0, 5))
            0:       return CH_SEMI;
            1:       return CH_LBRACE;
            2:       return CH_RBRACE;
            3:       return CH_ASSIGN;
            4:       return CH_PLUS;
            default: return CH_MINUS;
        endcase
    endfunction

    // whatever ends a plain token
    task automatic send_word_end();
        case ($urandom_range(0, 4))
            0:       send_item(OP_CHAR, CH_SPACE);
            1:       send_item(OP_CHAR, CH_TAB);
            2:       send_item(OP_EOL, 8'($urandom_range(0, 255)));
            default: send_item(OP_CHAR, pick_delim());
        endcase
    endtask

    // one random piece of source text, mostly well formed
    task automatic send_phrase();
        int n;
        logic [7:0] c;
        case ($urandom_range(0, 19))
            0, 1, 2: begin
                // keyword, sometimes with a stray tail so it misses
                case ($urandom_range(0, 2))
                    0:       send_text("int");
                    1:       send_text("float");
                    default: send_text("string");
                endcase
                if ($urandom_range(0, 3) == 0)
                    send_item(OP_CHAR, pick_plain());
                send_word_end();
            end
            3, 4, 5, 6: begin
                n = $urandom_range(1, 6);
                repeat (n) send_item(OP_CHAR, pick_plain());
                send_word_end();
            end
            7, 8: send_item(OP_CHAR, pick_delim());
            9, 10, 11: begin
                // literal, now and then longer than the buffer or across lines
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 6);
                if ($urandom_range(0, 2) == 0)
                    send_item(OP_CHAR, pick_plain());
                send_item(OP_CHAR, CH_QUOTE);
                repeat (n) begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CH_QUOTE || $urandom_range(0, 9) == 0)
                        send_item(OP_EOL, c);
                    else
                        send_item(OP_CHAR, c);
                end
                send_item(OP_CHAR, CH_QUOTE);
            end
            12: begin
                // plain token past the buffer size
                n = $urandom_range(TOK_MAX + 1, TOK_MAX + 8);
                repeat (n) send_item(OP_CHAR, pick_plain());
                send_word_end();
            end
            13: begin
                // line comment with any bytes after it
                if ($urandom_range(0, 1) == 0)
                    send_item(OP_CHAR, pick_plain());
                send_item(OP_CHAR, CH_SLASH);
                send_item(OP_CHAR, CH_SLASH);
                n = $urandom_range(0, 5);
                repeat (n) send_item(OP_CHAR, 8'($urandom_range(0, 255)));
                send_item(OP_EOL, 8'($urandom_range(0, 255)));
            end
            14: begin
                // block comment, its body possibly broken over lines
                if ($urandom_range(0, 1) == 0)
                    send_item(OP_CHAR, pick_plain());
                send_item(OP_CHAR, CH_SLASH);
                send_item(OP_CHAR, CH_STAR);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0)
                        send_item(OP_EOL, 8'($urandom_range(0, 255)));
                    else
                        send_item(OP_CHAR, pick_plain());
                end
                send_item(OP_CHAR, CH_STAR);
                send_item(OP_CHAR, CH_SLASH);
            end
            15: begin
                // comment marks split by a line break do not pair
                case ($urandom_range(0, 2))
                    0: begin
                        send_item(OP_CHAR, CH_SLASH);
                        send_item(OP_EOL, 8'($urandom_range(0, 255)));
                        send_item(OP_CHAR, CH_STAR);
                    end
                    1: begin
                        send_item(OP_CHAR, CH_SLASH);
                        send_item(OP_EOL, 8'($urandom_range(0, 255)));
                        send_item(OP_CHAR, CH_SLASH);
                    end
                    default: begin
                        send_item(OP_CHAR, CH_SLASH);
                        send_item(OP_CHAR, CH_STAR);
                        send_item(OP_CHAR, CH_STAR);
                        send_item(OP_EOL, 8'($urandom_range(0, 255)));
                        send_item(OP_CHAR, CH_SLASH);
                        send_item(OP_CHAR, CH_STAR);
                        send_item(OP_CHAR, CH_SLASH);
                    end
                endcase
                send_item(OP_CHAR, CH_SPACE);
            end
            16: send_item(OP_EOL, 8'($urandom_range(0, 255)));
            17, 18: begin
                // raw noise, then a space so a stray slash cannot pair with what follows
                n = $urandom_range(1, 3);
                repeat (n) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                send_item(OP_CHAR, CH_SPACE);
            end
            default: begin
                // number with a fraction
                n = $urandom_range(1, 4);
                repeat (n) send_item(OP_CHAR, 8'h30 + 8'($urandom_range(0, 9)));
                send_text(".");
                n = $urandom_range(0, 3);
                repeat (n) send_item(OP_CHAR, 8'h30 + 8'($urandom_range(0, 9)));
                send_word_end();
            end
        endcase
    endtask

    task automatic add_row(input logic op, input logic [7:0] ch);
        t_text_row r;
        r.op = op;
        r.ch = ch;
        r.typed = 1'b0;
        r.want = '{default: '0};
        text_plan.insert(text_plan.size(), r);
    endtask

    // one-character token on line 1 with its result written out
    task automatic add_typed(input logic [7:0] ch, input logic [3:0] k, input logic [15:0] d,
                             input logic [15:0] s);
        t_text_row r;
        r.op = OP_CHAR;
        r.ch = ch;
        r.typed = 1'b1;
        r.want.out_char = ch;
        r.want.kind = k;
        r.want.line_no = 16'd1;
        r.want.depth = d;
        r.want.scope = s;
        r.want.last_char = 1'b1;
        r.want.truncated = 1'b0;
        text_plan.insert(text_plan.size(), r);
    endtask

    // ---------------------------------------------------------------
    // receiver side and checking
    // ---------------------------------------------------------------

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    initial begin
        int stall;
        t_tok_res want;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_armed) begin
                // long hold-off so the block backs up and stalls its input
                hold_armed = 1'b0;
                stall = LONG_HOLD;
            end else begin
                stall = full_rate ? 0 : $urandom_range(0, 11);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            results_checked++;
            if (tok_expect.size() == 0) begin
                $error("result item with nothing expected: out_char 0x%0h", o_out_char);
                errors++;
            end else begin
                want = tok_expect.pop_front();
                check_field("out_char", 16'(want.out_char), 16'(o_out_char));
                check_field("kind", 16'(want.kind), 16'(o_kind));
                check_field("line_no", want.line_no, o_line_no);
                check_field("depth", want.depth, o_depth);
                check_field("scope", want.scope, o_scope);
                check_field("last_char", 16'(want.last_char), 16'(o_last_char));
                check_field("truncated", 16'(want.truncated), 16'(o_truncated));
            end
        end
    end

    // watchdog: too long without any handshake ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) === 1'b1 || (o_out_valid && i_out_ready) === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, tok_expect.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    initial begin
        int r;
        int mark;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // delimiters straight after reset: line 1, depth and scope from zero
        add_typed(CH_SEMI,   KIND_SEMI,   16'd0,    16'd0);
        add_typed(CH_LBRACE, KIND_LBRACE, 16'd1,    16'd1);
        add_typed(CH_RBRACE, KIND_RBRACE, 16'd0,    16'd2);
        // closing below zero wraps depth to -1
        add_typed(CH_RBRACE, KIND_RBRACE, 16'hFFFF, 16'd3);
        add_typed(CH_ASSIGN, KIND_ASSIGN, 16'hFFFF, 16'd3);
        add_typed(CH_PLUS,   KIND_PLUS,   16'hFFFF, 16'd3);
        add_typed(CH_MINUS,  KIND_MINUS,  16'hFFFF, 16'd3);
        // keyword ended by a tab
        add_row(OP_CHAR, "i");
        add_row(OP_CHAR, "n");
        add_row(OP_CHAR, "t");
        add_row(OP_CHAR, CH_TAB);
        // extreme bytes as a plain token, ended by an end of line with all ones
        add_row(OP_CHAR, 8'hFF);
        add_row(OP_CHAR, 8'h00);
        add_row(OP_EOL, 8'hFF);
        // line comment drops the pending token and the rest of the line
        add_row(OP_CHAR, "q");
        add_row(OP_CHAR, CH_SLASH);
        add_row(OP_CHAR, CH_SLASH);
        add_row(OP_CHAR, "z");
        add_row(OP_EOL, 8'h00);
        // quote after pending text, line break inside the literal
        add_row(OP_CHAR, "k");
        add_row(OP_CHAR, CH_QUOTE);
        add_row(OP_EOL, 8'h00);
        add_row(OP_CHAR, CH_QUOTE);
        // block comment across a line break
        add_row(OP_CHAR, CH_SLASH);
        add_row(OP_CHAR, CH_STAR);
        add_row(OP_EOL, 8'h00);
        add_row(OP_CHAR, CH_STAR);
        add_row(OP_CHAR, CH_SLASH);

        for (r = 0; r < text_plan.size(); r++) begin
            send_item(text_plan[r].op, text_plan[r].ch);
            // typed rows give one result: the written-out value stands in for it
            if (text_plan[r].typed) begin
                tok_expect[tok_expect.size() - 1] = text_plan[r].want;
            end
        end

        // random text, with stretches at full rate and one long receiver hold-off
        hold_armed = 1'b1;
        mark = items_sent;
        while (items_sent - mark < RANDOM_ITEMS) begin
            if ($urandom_range(0, 15) == 0)
                full_rate = !full_rate;
            send_phrase();
        end

        // close whatever is still open, then end the last plain token
        while (lex_mode != MODE_NORMAL) begin
            case (lex_mode)
                MODE_LITERAL: send_item(OP_CHAR, CH_QUOTE);
                MODE_BLOCK: begin
                    send_item(OP_CHAR, CH_STAR);
                    send_item(OP_CHAR, CH_SLASH);
                end
                default: send_item(OP_EOL, 8'h00);
            endcase
        end
        send_item(OP_CHAR, CH_SPACE);

        i_in_valid <= 1'b0;
        while (tok_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d input items, %0d result items checked", items_sent, results_checked);
        $display("covered: delimiters from reset, depth below zero, random phrases, long stall");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
